[hdl/i2c_master_bit_sequencer_assert.svh]
// Assertion macros shared by the I2C master bit sequencer modules.
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define I2CMS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define I2CMS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/i2cms_pkg.sv]
// Types, constants and phase decode for the I2C master bit sequencer.
package i2cms_pkg;

  localparam int unsigned QueueDepthDefault = 2;
  localparam logic [15:0] PhaseTicksReset   = 16'd10;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_STOP  = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_SACK  = 3'd4,
    OP_DACK  = 3'd5,
    OP_DNACK = 3'd6
  } opcode_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_data;
    logic [7:0] line_samples;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       last_phase;
    logic [7:0] read_data;
    logic       no_ack;
  } phase_t;

  // Position within a command's run: bit index and phase within the bit
  typedef struct packed {
    logic [2:0] bit_idx;
    logic [1:0] sub;
  } pos_t;

  // Bus levels and end flags for one phase of a command
  function automatic phase_t phase_of(cmd_t c, pos_t p);
    phase_t r;
    logic   b;
    r = '0;
    b = c.write_data[~p.bit_idx];
    case (c.opcode)
      OP_START: begin
        r.scl_level  = (p.sub != 2'd2);
        r.sda_level  = (p.sub == 2'd0);
        r.last_phase = (p.sub == 2'd2);
      end
      OP_STOP: begin
        r.scl_level  = 1'b1;
        r.sda_level  = (p.sub == 2'd1);
        r.last_phase = (p.sub == 2'd1);
      end
      OP_WRITE: begin
        r.scl_level  = (p.sub == 2'd1);
        r.sda_level  = (p.sub == 2'd2 && p.bit_idx == 3'd7) ? 1'b1 : b;
        r.last_phase = (p.sub == 2'd2 && p.bit_idx == 3'd7);
      end
      OP_READ: begin
        r.scl_level  = (p.sub == 2'd0);
        r.sda_level  = 1'b1;
        r.last_phase = (p.sub == 2'd1 && p.bit_idx == 3'd7);
        r.read_data  = r.last_phase ? c.line_samples : 8'd0;
      end
      OP_SACK: begin
        r.scl_level  = (p.sub == 2'd1);
        r.sda_level  = 1'b1;
        r.last_phase = (p.sub == 2'd2);
        r.no_ack     = r.last_phase & c.line_samples[7];
      end
      OP_DACK: begin
        r.scl_level  = (p.sub == 2'd1);
        r.sda_level  = (p.sub == 2'd3);
        r.last_phase = (p.sub == 2'd3);
      end
      OP_DNACK: begin
        r.scl_level  = (p.sub == 2'd1);
        r.sda_level  = 1'b1;
        r.last_phase = (p.sub == 2'd2);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // Phase counter step: write bits have three phases, read bits two
  function automatic pos_t pos_step(logic [2:0] opcode, pos_t p);
    pos_t r;
    logic wrap;
    r = p;
    case (opcode)
      OP_WRITE: wrap = (p.sub == 2'd2);
      OP_READ:  wrap = (p.sub == 2'd1);
      default:  wrap = 1'b0;
    endcase
    if (wrap) begin
      r.sub     = 2'd0;
      r.bit_idx = p.bit_idx + 3'd1;
    end else begin
      r.sub = p.sub + 2'd1;
    end
    return r;
  endfunction

endpackage

[hdl/i2cms_front.sv]
// Command intake: drops unknown opcodes and queues the rest for the sequencer.
module i2cms_front #(
  parameter int unsigned QDEPTH = i2cms_pkg::QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  i2cms_pkg::cmd_t     cmd,
  output logic                q_valid,
  input  logic                q_pop,
  output i2cms_pkg::cmd_t     q_head
);

  localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  i2cms_pkg::cmd_t mem [QDEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            accept;
  logic            known;
  logic            push;
  logic            pop;

  // Classify the incoming command
  always_comb begin
    case (cmd.opcode)
      i2cms_pkg::OP_START, i2cms_pkg::OP_STOP, i2cms_pkg::OP_WRITE,
      i2cms_pkg::OP_READ, i2cms_pkg::OP_SACK, i2cms_pkg::OP_DACK,
      i2cms_pkg::OP_DNACK: known = 1'b1;
      default:             known = 1'b0;
    endcase
  end

  assign cmd_stall = (count == CntW'(QDEPTH));
  assign accept    = cmd_valid & ~cmd_stall;
  assign push      = accept & known;
  assign pop       = q_pop & q_valid;
  assign q_valid   = (count != '0);
  assign q_head    = mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd;
    end
  end

  // Queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

`include "i2c_master_bit_sequencer_assert.svh"

  `I2CMS_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, count <= CntW'(QDEPTH), "queue overfilled")
  `I2CMS_ASSERT_NXT(a_drop_unknown, clk, rst, accept && !known, count == $past(count) - CntW'($past(pop)), "unknown opcode queued")
  `I2CMS_ASSERT_IMP(a_pop_nonempty, clk, rst, q_pop, q_valid, "pop from empty queue")

endmodule

[hdl/i2cms_back.sv]
// Phase sequencer: runs each queued command as timed bus phases into an output register.
module i2cms_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         phase_ticks,
  input  logic                q_valid,
  output logic                q_pop,
  input  i2cms_pkg::cmd_t     q_head,
  output logic                phase_valid,
  input  logic                phase_stall,
  output i2cms_pkg::phase_t   phase
);

  i2cms_pkg::cmd_t   cur;
  i2cms_pkg::pos_t   pos;
  i2cms_pkg::phase_t nxt_phase;
  logic              busy;
  logic [15:0]       wait_cnt;
  logic              out_free;
  logic              emit;

  assign nxt_phase = i2cms_pkg::phase_of(cur, pos);
  assign out_free  = ~phase_valid | ~phase_stall;
  assign emit      = busy & (wait_cnt == '0) & out_free;
  assign q_pop     = q_valid & (~busy | (emit & nxt_phase.last_phase));

  // Command register and phase position
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      pos  <= '0;
    end else if (emit) begin
      busy <= ~nxt_phase.last_phase;
      pos  <= i2cms_pkg::pos_step(cur.opcode, pos);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // Phase hold timer
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_cnt <= '0;
    end else if (emit) begin
      wait_cnt <= (phase_ticks == '0) ? '0 : phase_ticks - 16'd1;
    end else if (wait_cnt != '0) begin
      wait_cnt <= wait_cnt - 16'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_valid <= 1'b0;
    end else if (emit) begin
      phase_valid <= 1'b1;
    end else if (!phase_stall) begin
      phase_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      phase <= nxt_phase;
    end
  end

`include "i2c_master_bit_sequencer_assert.svh"

  `I2CMS_ASSERT_NXT(a_load_pos, clk, rst, q_pop, busy && pos == '0, "new command not started at first phase")
  `I2CMS_ASSERT_NXT(a_run_end, clk, rst, emit && nxt_phase.last_phase && !q_pop, !busy, "sequencer busy after last phase")
  `I2CMS_ASSERT_NXT(a_hold, clk, rst, emit && phase_ticks > 16'd1, !emit, "phase not held")

endmodule

[hdl/i2c_master_bit_sequencer.sv]
// A command beat accepted by an idle sequencer whose hold timer has run out passes
// through the queue and the command register to the output phase register.
// Phase beats are paced by the phase hold timer loaded from phase_ticks and held
// by phase_stall; a write byte runs as 24 phases.
// Commands queue while a run is in progress; opcode 7 is taken and dropped.
// Reset: synchronous, active high; phase_ticks returns to 10, queue empties.
module i2c_master_bit_sequencer #(
  parameter int unsigned QDEPTH = i2cms_pkg::QueueDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  i2cms_pkg::cmd_t     cmd,
  output logic                phase_valid,
  input  logic                phase_stall,
  output i2cms_pkg::phase_t   phase,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  logic [15:0]     phase_ticks;
  logic            q_valid;
  logic            q_pop;
  i2cms_pkg::cmd_t q_head;

  // Phase length register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cms_pkg::PhaseTicksReset;
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks <= cfg_data;
    end
  end

  i2cms_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  i2cms_back u_back (
    .clk         (clk),
    .rst         (rst),
    .phase_ticks (phase_ticks),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_head      (q_head),
    .phase_valid (phase_valid),
    .phase_stall (phase_stall),
    .phase       (phase)
  );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the I2C master bit sequencer: commands in, bus phase beats out.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode that the block takes and drops without any phase
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int unsigned SETTLE_BASE = 8;
  localparam int unsigned SETTLE_CAP = 64;

  logic              clk;
  logic              rst = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  i2cms_pkg::cmd_t   cmd = '0;
  logic              phase_valid;
  logic              phase_stall = 1'b0;
  i2cms_pkg::phase_t phase;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [15:0]       cfg_data = '0;

  // Pending commands, expected phase beats and bookkeeping
  i2cms_pkg::cmd_t   cmd_queue[$];
  i2cms_pkg::phase_t expected_phases[$];
  int unsigned cmds_queued = 0;
  int unsigned cmds_accepted = 0;
  int unsigned errors = 0;
  int unsigned send_gap = 0;
  int unsigned send_calm = 0;
  int unsigned stall_left = 0;
  int unsigned stall_calm = 0;
  logic [15:0] hold_ticks = i2cms_pkg::PhaseTicksReset;

  i2c_master_bit_sequencer dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .phase_valid (phase_valid),
    .phase_stall (phase_stall),
    .phase       (phase),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap lengths: mostly none or short, a few long, with calm stretches of none
  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 4) begin
      calm = $urandom_range(40, 10);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(50, 8);
  endfunction

  function automatic i2cms_pkg::phase_t bus_level(input logic scl, input logic sda);
    i2cms_pkg::phase_t p;
    p = '0;
    p.scl_level = scl;
    p.sda_level = sda;
    return p;
  endfunction

  // Bus phase predictor: the run of SCL/SDA levels one command produces
  task automatic predict_bus_phases(input i2cms_pkg::cmd_t c);
    i2cms_pkg::phase_t run[$];
    i2cms_pkg::phase_t tail;
    logic              b;
    case (c.opcode)
      i2cms_pkg::OP_START: begin
        run.push_back(bus_level(1'b1, 1'b1));
        run.push_back(bus_level(1'b1, 1'b0));
        run.push_back(bus_level(1'b0, 1'b0));
      end
      i2cms_pkg::OP_STOP: begin
        run.push_back(bus_level(1'b1, 1'b0));
        run.push_back(bus_level(1'b1, 1'b1));
      end
      i2cms_pkg::OP_WRITE: begin
        // MSB first; SDA released after the last bit
        for (int i = 7; i >= 0; i--) begin
          b = c.write_data[i];
          run.push_back(bus_level(1'b0, b));
          run.push_back(bus_level(1'b1, b));
          run.push_back(bus_level(1'b0, (i == 0) ? 1'b1 : b));
        end
      end
      i2cms_pkg::OP_READ: begin
        for (int i = 0; i < 8; i++) begin
          run.push_back(bus_level(1'b1, 1'b1));
          run.push_back(bus_level(1'b0, 1'b1));
        end
      end
      i2cms_pkg::OP_SACK, i2cms_pkg::OP_DNACK: begin
        run.push_back(bus_level(1'b0, 1'b1));
        run.push_back(bus_level(1'b1, 1'b1));
        run.push_back(bus_level(1'b0, 1'b1));
      end
      i2cms_pkg::OP_DACK: begin
        run.push_back(bus_level(1'b0, 1'b0));
        run.push_back(bus_level(1'b1, 1'b0));
        run.push_back(bus_level(1'b0, 1'b0));
        run.push_back(bus_level(1'b0, 1'b1));
      end
      default: ;
    endcase
    if (run.size() == 0) return;
    // Final phase carries the end flag and any sampled result
    tail = run.pop_back();
    tail.last_phase = 1'b1;
    if (c.opcode == i2cms_pkg::OP_READ) tail.read_data = c.line_samples;
    if (c.opcode == i2cms_pkg::OP_SACK) tail.no_ack = c.line_samples[7];
    run.push_back(tail);
    foreach (run[k]) expected_phases.push_back(run[k]);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        predict_bus_phases(cmd);
        cmds_accepted++;
      end
      if (!cmd_valid || !cmd_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          cmd <= cmd_queue.pop_front();
          cmd_valid <= 1'b1;
          send_gap = draw_gap(send_calm);
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Phase monitor and receiver stalls
  always @(posedge clk) begin : phase_mon
    i2cms_pkg::phase_t want;
    if (rst) begin
      phase_stall <= 1'b0;
    end else begin
      if (phase_valid && !phase_stall) begin
        if (expected_phases.size() == 0) begin
          $error("phase beat with none expected: %0h", phase);
          errors++;
        end else begin
          want = expected_phases.pop_front();
          check_field("scl_level", 32'(want.scl_level), 32'(phase.scl_level));
          check_field("sda_level", 32'(want.sda_level), 32'(phase.sda_level));
          check_field("last_phase", 32'(want.last_phase), 32'(phase.last_phase));
          check_field("read_data", 32'(want.read_data), 32'(phase.read_data));
          check_field("no_ack", 32'(want.no_ack), 32'(phase.no_ack));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        phase_stall <= 1'b1;
      end else begin
        stall_left = draw_gap(stall_calm);
        if (stall_left > 0) begin
          stall_left--;
          phase_stall <= 1'b1;
        end else begin
          phase_stall <= 1'b0;
        end
      end
    end
  end

  task automatic queue_cmd(input logic [2:0] op, input logic [7:0] wd,
                           input logic [7:0] ls);
    i2cms_pkg::cmd_t c;
    c.opcode = op;
    c.write_data = wd;
    c.line_samples = ls;
    cmd_queue.push_back(c);
    cmds_queued++;
  endtask

  // Wait for every beat of every command, then let the block settle
  task automatic drain;
    int unsigned settle;
    while (cmds_accepted != cmds_queued || expected_phases.size() != 0) @(posedge clk);
    settle = 2 * ((hold_ticks == 16'd0) ? 32'd1 : 32'(hold_ticks));
    settle = SETTLE_BASE + ((settle > SETTLE_CAP) ? SETTLE_CAP : settle);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_phase_ticks(input logic [15:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hold_ticks = v;
  endtask

  // Mostly well-formed transfers with random content, the rest noise
  task automatic queue_traffic(input int unsigned target);
    int unsigned done_n;
    int unsigned len;
    logic [7:0]  addr;
    logic [2:0]  op;
    done_n = 0;
    while (done_n < target) begin
      if ($urandom_range(99) < 80) begin
        addr = 8'($urandom);
        len = $urandom_range(4, 1);
        queue_cmd(i2cms_pkg::OP_START, 8'($urandom), 8'($urandom));
        queue_cmd(i2cms_pkg::OP_WRITE, addr, 8'($urandom));
        queue_cmd(i2cms_pkg::OP_SACK, 8'($urandom), 8'($urandom));
        for (int k = 0; k < len; k++) begin
          if (addr[0]) begin
            queue_cmd(i2cms_pkg::OP_READ, 8'($urandom), 8'($urandom));
            queue_cmd((k == len - 1) ? i2cms_pkg::OP_DNACK : i2cms_pkg::OP_DACK,
                      8'($urandom), 8'($urandom));
          end else begin
            queue_cmd(i2cms_pkg::OP_WRITE, 8'($urandom), 8'($urandom));
            queue_cmd(i2cms_pkg::OP_SACK, 8'($urandom), 8'($urandom));
          end
        end
        done_n += 3 + 2 * len;
        // Occasionally leave the transfer without its stop
        if ($urandom_range(9) != 0) begin
          queue_cmd(i2cms_pkg::OP_STOP, 8'($urandom), 8'($urandom));
          done_n++;
        end
      end else begin
        op = 3'($urandom_range(7));
        queue_cmd(op, 8'($urandom), 8'($urandom));
        if (op != OP_UNUSED) done_n++;
      end
    end
  endtask

  // Run sequence: directed commands at the reset timing, then random traffic at several phase lengths
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    queue_cmd(i2cms_pkg::OP_START, 8'h00, 8'h00);
    queue_cmd(i2cms_pkg::OP_WRITE, 8'h00, 8'hFF);
    queue_cmd(i2cms_pkg::OP_WRITE, 8'hFF, 8'h00);
    queue_cmd(i2cms_pkg::OP_WRITE, 8'hA5, 8'h5A);
    queue_cmd(i2cms_pkg::OP_WRITE, 8'h5A, 8'hA5);
    queue_cmd(i2cms_pkg::OP_SACK, 8'h00, 8'h80);
    queue_cmd(i2cms_pkg::OP_SACK, 8'hFF, 8'h7F);
    queue_cmd(i2cms_pkg::OP_READ, 8'h00, 8'hFF);
    queue_cmd(i2cms_pkg::OP_READ, 8'hFF, 8'h00);
    queue_cmd(i2cms_pkg::OP_READ, 8'h3C, 8'h96);
    queue_cmd(i2cms_pkg::OP_DACK, 8'hFF, 8'hFF);
    queue_cmd(i2cms_pkg::OP_DNACK, 8'h00, 8'h00);
    queue_cmd(OP_UNUSED, 8'hFF, 8'hFF);
    queue_cmd(OP_UNUSED, 8'h00, 8'h00);
    queue_cmd(i2cms_pkg::OP_STOP, 8'hFF, 8'hFF);
    drain();

    set_phase_ticks(16'd1);
    queue_traffic(100);
    drain();

    set_phase_ticks(16'd0);
    queue_traffic(60);
    drain();

    // Longest hold: keep it to a single short command
    set_phase_ticks(16'hFFFF);
    queue_cmd(i2cms_pkg::OP_STOP, 8'($urandom), 8'($urandom));
    queue_cmd(OP_UNUSED, 8'($urandom), 8'($urandom));
    drain();

    set_phase_ticks(16'($urandom_range(16, 2)));
    queue_traffic(100);
    drain();

    set_phase_ticks(16'($urandom_range(24, 2)));
    queue_traffic(100);
    drain();

    set_phase_ticks(i2cms_pkg::PhaseTicksReset);
    queue_traffic(70);
    drain();

    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

[i2c_master_bit_sequencer.f]
+incdir+hdl
hdl/i2cms_pkg.sv
hdl/i2cms_front.sv
hdl/i2cms_back.sv
hdl/i2c_master_bit_sequencer.sv
tb/testbench.sv
